// ===== src/jspv_pkg.sv =====
// Package for the streaming JSON path/value parser.
// Holds the word types of both channels and shared constants; no dependencies.
package jspv_pkg;

   typedef struct packed {
      logic       op;
      logic [7:0] text_in;
   } req_word_type;

   typedef struct packed {
      logic       event_kind;
      logic [3:0] depth_now;
      logic       part;
      logic [7:0] text_out;
      logic       text_valid;
      logic       last;
   } rsp_word_type;

   localparam logic OP_PARSE   = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   localparam logic [7:0] CH_SEP    = 8'h2F;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   localparam int MAX_RESULTS = 64;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd16;
      if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h61 + 8'd10);
      else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h41 + 8'd10);
      return r;
   endfunction

endpackage

// ===== src/jspv_front.sv =====
// Input side of the parser: a two-word queue that holds accepted words.
// Depends on jspv_pkg for the request word type.
module jspv_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  jspv_pkg::req_word_type req_word,
   output logic                  q_valid,
   input  logic                  q_take,
   output jspv_pkg::req_word_type q_word
);
   import jspv_pkg::*;

   req_word_type mem_ff [2];
   logic         wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_valid && q_take;
   assign q_word    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = 2'(cnt_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= req_word;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== src/jspv_back.sv =====
// Execution side: parse state machine, buffers, path edits and event emission.
// Depends on jspv_pkg for word types, character codes and helper functions.
module jspv_back #(
   parameter int PATH_BYTES  = 32,
   parameter int KEY_BYTES   = 16,
   parameter int VALUE_BYTES = 16,
   parameter int MAX_DEPTH   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_take,
   input  jspv_pkg::req_word_type q_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output jspv_pkg::rsp_word_type rsp_word
);
   import jspv_pkg::*;

   localparam int PW = $clog2(PATH_BYTES);
   localparam int KW = $clog2(KEY_BYTES);
   localparam int VW = $clog2(VALUE_BYTES);
   localparam int DW = $clog2(MAX_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_INIT, PH_PRE_NAME, PH_Q_NAME, PH_ASSIGN, PH_PRE_VALUE, PH_Q_VALUE,
      PH_ESC, PH_ESCU, PH_NUM, PH_PRE_ITEM, PH_POST_ITEM, PH_PRE_DONE,
      PH_DONE, PH_ERROR
   } phase_type;

   // Sequencer steps: decode a word, append bytes to the path, search for a
   // cut mark, or play an event out on the result channel.
   typedef enum logic [2:0] {
      ST_IDLE, ST_APPEND, ST_CUT, ST_EMIT, ST_EMIT_WAIT
   } step_type;

   // What to do after a cut search finishes.
   typedef enum logic [2:0] {
      CT_NEXT_ITEM, CT_CLOSE_ARR, CT_CLOSE_SEP, CT_POST_CLOSE, CT_OBJ_CLOSE
   } cut_type;

   // Emission segments.
   typedef enum logic [2:0] {
      SG_PATH, SG_SEP, SG_KEY, SG_VALUE, SG_EMPTY
   } seg_type;

   phase_type    phase_ff;
   step_type     step_ff;
   logic [DW-1:0] level_ff;
   logic [8:0]   lidx_ff [MAX_DEPTH + 1];
   logic [7:0]   path_ff [PATH_BYTES];
   logic [PW:0]  plen_ff;
   logic [7:0]   key_ff [KEY_BYTES];
   logic [KW:0]  klen_ff;
   logic [7:0]   val_ff [VALUE_BYTES];
   logic [VW:0]  vlen_ff;
   logic [15:0]  hex_ff;
   logic [2:0]   hcnt_ff;
   logic         hstop_ff;

   // Append queue: up to five generated bytes, then optionally key bytes.
   logic [7:0]   ap_ff [5];
   logic [2:0]   ap_n_ff, ap_i_ff;
   logic         ap_key_ff;
   logic [KW:0]  ap_k_ff;
   logic         ap_emit_ff;     // emit the path after appending
   logic         ap_open_ff;     // open a level after (emit) append
   logic         ap_obj_ff;
   logic         ap_redo_ff;     // re-examine the byte after append

   logic [PW:0]  cut_i_ff;
   logic [7:0]   cut_mark_ff;
   cut_type      cut_kind_ff;

   logic         ev_kind_ff;
   seg_type      seg_ff;
   logic [PW:0]  ei_ff;
   logic [6:0]   ecount_ff;
   logic         redo_ff;       // re-examine the byte on the next idle step
   logic [7:0]   byte_ff;       // byte being worked on
   logic         open_after_ff;
   logic         open_obj_ff;

   rsp_word_type out_ff;
   logic         out_v_ff;

   logic [7:0]   c;
   logic         blanks;
   logic [7:0]   cur_idx;
   logic [8:0]   prev_lidx;
   logic [7:0]   hund, tens, ones;
   logic [7:0]   t10;

   assign c         = redo_ff ? byte_ff : q_word.text_in;
   assign q_take    = (step_ff == ST_IDLE) && !redo_ff && q_valid;
   assign rsp_valid = out_v_ff;
   assign rsp_word  = out_ff;
   assign cur_idx   = lidx_ff[level_ff][7:0];
   assign prev_lidx = lidx_ff[DW'(level_ff - 1'b1)];
   assign blanks    = !(phase_ff == PH_Q_NAME || phase_ff == PH_Q_VALUE ||
                        phase_ff == PH_ESC || phase_ff == PH_ESCU ||
                        phase_ff == PH_NUM);

   // Small-constant decimal split of the array count.
   always_comb begin
      hund = (cur_idx >= 8'd200) ? 8'd2 : (cur_idx >= 8'd100) ? 8'd1 : 8'd0;
      t10  = 8'(cur_idx - 8'(hund * 8'd100));
      tens = 8'((16'(t10) * 16'd205) >> 11);
      ones = 8'(t10 - 8'(tens * 8'd10));
   end

   always_ff @(posedge clock) begin
      logic [7:0] cc;
      logic [4:0] h;
      logic [2:0] n;
      logic       go;
      logic       out_free;
      logic [7:0] eb;
      logic       ev;
      logic       elast;
      logic       lastseg;
      logic       ov;
      out_free = !out_v_ff || !rsp_stall;
      ov = out_v_ff && rsp_stall;
      if (reset) begin
         phase_ff   <= PH_INIT;
         step_ff    <= ST_IDLE;
         level_ff   <= '0;
         for (int i = 1; i <= MAX_DEPTH; i++) lidx_ff[i] <= 9'h000;
         lidx_ff[0] <= 9'h100;
         plen_ff    <= '0;
         klen_ff    <= '0;
         vlen_ff    <= '0;
         hex_ff     <= '0;
         hcnt_ff    <= '0;
         hstop_ff   <= 1'b0;
         redo_ff    <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         case (step_ff)
         ST_IDLE: begin
            go = redo_ff || q_valid;
            if (go) begin
               redo_ff <= 1'b0;
               byte_ff <= c;
               if (!redo_ff && q_word.op == OP_RESTART) begin
                  phase_ff   <= PH_INIT;
                  level_ff   <= '0;
                  for (int i = 1; i <= MAX_DEPTH; i++) lidx_ff[i] <= 9'h000;
                  lidx_ff[0] <= 9'h100;
                  plen_ff    <= '0;
                  klen_ff    <= '0;
                  vlen_ff    <= '0;
                  hex_ff     <= '0;
                  hcnt_ff    <= '0;
                  hstop_ff   <= 1'b0;
               end else if (blanks && is_blank(c)) begin
                  // Skipped.
               end else begin
                  case (phase_ff)
                  PH_ERROR: ;
                  PH_DONE: phase_ff <= PH_ERROR;
                  PH_INIT: begin
                     if (c != CH_LBRACE) phase_ff <= PH_ERROR;
                     else if (32'(level_ff) >= MAX_DEPTH) phase_ff <= PH_ERROR;
                     else begin
                        level_ff <= DW'(level_ff + 1'b1);
                        lidx_ff[DW'(level_ff + 1'b1)] <= 9'h100;
                        phase_ff <= PH_PRE_NAME;
                     end
                  end
                  PH_PRE_NAME: begin
                     if (c == CH_QUOTE) begin
                        klen_ff  <= '0;
                        vlen_ff  <= '0;
                        phase_ff <= PH_Q_NAME;
                     end else begin
                        phase_ff <= PH_PRE_DONE;
                        redo_ff  <= 1'b1;
                     end
                  end
                  PH_Q_NAME: begin
                     if (c == CH_QUOTE) phase_ff <= PH_ASSIGN;
                     else if (32'(klen_ff) + 1 < KEY_BYTES) begin
                        key_ff[klen_ff[KW-1:0]] <= c;
                        klen_ff <= KW'(klen_ff) + 1'b1;
                     end
                  end
                  PH_ASSIGN: phase_ff <= (c == CH_COLON) ? PH_PRE_VALUE : PH_ERROR;
                  PH_PRE_ITEM: begin
                     ap_ff[0] <= CH_LBRACK;
                     n = 3'd1;
                     if (cur_idx >= 8'd100) begin
                        ap_ff[n] <= CH_ZERO + hund;
                        n = n + 3'd1;
                     end
                     if (cur_idx >= 8'd10) begin
                        ap_ff[n] <= CH_ZERO + tens;
                        n = n + 3'd1;
                     end
                     ap_ff[n] <= CH_ZERO + ones;
                     n = n + 3'd1;
                     ap_ff[n] <= CH_RBRACK;
                     n = n + 3'd1;
                     ap_n_ff   <= n;
                     ap_i_ff   <= '0;
                     ap_key_ff <= 1'b0;
                     ap_emit_ff <= 1'b0;
                     if (c == CH_LBRACE) begin
                        ap_open_ff <= 1'b1;
                        ap_obj_ff  <= 1'b1;
                        ap_redo_ff <= 1'b0;
                     end else begin
                        klen_ff    <= '0;
                        phase_ff   <= PH_PRE_VALUE;
                        ap_open_ff <= 1'b0;
                        ap_redo_ff <= 1'b1;
                     end
                     step_ff <= ST_APPEND;
                  end
                  PH_POST_ITEM: begin
                     if (c == CH_COMMA) begin
                        lidx_ff[level_ff] <= {lidx_ff[level_ff][8],
                                              8'(cur_idx + 8'd1)};
                        phase_ff <= PH_PRE_ITEM;
                     end else if (c == CH_RBRACK) begin
                        if (level_ff == '0) phase_ff <= PH_ERROR;
                        else if (level_ff > DW'(2)) begin
                           cut_i_ff    <= plen_ff;
                           cut_mark_ff <= CH_SEP;
                           cut_kind_ff <= CT_POST_CLOSE;
                           step_ff     <= ST_CUT;
                        end else begin
                           plen_ff  <= '0;
                           level_ff <= DW'(level_ff - 1'b1);
                           phase_ff <= PH_PRE_DONE;
                        end
                     end
                  end
                  PH_PRE_VALUE: begin
                     vlen_ff <= '0;
                     if (c == CH_QUOTE) phase_ff <= PH_Q_VALUE;
                     else if (c == CH_LBRACE || c == CH_LBRACK) begin
                        n = 3'd0;
                        if (plen_ff != '0) begin
                           ap_ff[0] <= CH_SEP;
                           n = 3'd1;
                        end
                        ap_n_ff    <= n;
                        ap_i_ff    <= '0;
                        ap_key_ff  <= 1'b1;
                        ap_k_ff    <= '0;
                        ap_emit_ff <= 1'b1;
                        ap_open_ff <= 1'b1;
                        ap_obj_ff  <= (c == CH_LBRACE);
                        ap_redo_ff <= 1'b0;
                        step_ff    <= ST_APPEND;
                     end else if (is_digit(c)) begin
                        phase_ff <= PH_NUM;
                        redo_ff  <= 1'b1;
                     end
                  end
                  PH_NUM: begin
                     if (is_digit(c) || c == CH_DOT) begin
                        if (32'(vlen_ff) + 1 < VALUE_BYTES) begin
                           val_ff[vlen_ff[VW-1:0]] <= c;
                           vlen_ff <= VW'(vlen_ff) + 1'b1;
                        end
                     end else begin
                        phase_ff      <= PH_PRE_DONE;
                        ev_kind_ff    <= 1'b1;
                        seg_ff        <= SG_PATH;
                        ei_ff         <= '0;
                        ecount_ff     <= '0;
                        open_after_ff <= 1'b0;
                        ap_redo_ff    <= 1'b1;
                        step_ff       <= ST_EMIT;
                     end
                  end
                  PH_Q_VALUE: begin
                     if (c == CH_BSLASH) phase_ff <= PH_ESC;
                     else if (c != CH_QUOTE) begin
                        if (32'(vlen_ff) + 1 < VALUE_BYTES) begin
                           val_ff[vlen_ff[VW-1:0]] <= c;
                           vlen_ff <= VW'(vlen_ff) + 1'b1;
                        end
                     end else begin
                        phase_ff      <= PH_PRE_DONE;
                        ev_kind_ff    <= 1'b1;
                        seg_ff        <= SG_PATH;
                        ei_ff         <= '0;
                        ecount_ff     <= '0;
                        open_after_ff <= 1'b0;
                        ap_redo_ff    <= 1'b0;
                        step_ff       <= ST_EMIT;
                     end
                  end
                  PH_ESC: begin
                     if (c == 8'h75) begin
                        hex_ff   <= '0;
                        hcnt_ff  <= '0;
                        hstop_ff <= 1'b0;
                        phase_ff <= PH_ESCU;
                     end else begin
                        cc = c;
                        if (c == 8'h62) cc = 8'd8;
                        else if (c == 8'h66) cc = 8'd12;
                        else if (c == 8'h6E) cc = 8'd10;
                        else if (c == 8'h72) cc = 8'd13;
                        else if (c == 8'h74) cc = 8'd9;
                        if (32'(vlen_ff) + 1 < VALUE_BYTES) begin
                           val_ff[vlen_ff[VW-1:0]] <= cc;
                           vlen_ff <= VW'(vlen_ff) + 1'b1;
                        end
                        phase_ff <= PH_Q_VALUE;
                     end
                  end
                  PH_ESCU: begin
                     h = hex_val(c);
                     cc = hex_ff[7:0];
                     if (h[4]) hstop_ff <= 1'b1;
                     else if (!hstop_ff) begin
                        hex_ff <= {hex_ff[11:0], h[3:0]};
                        cc = {hex_ff[3:0], h[3:0]};
                     end
                     if (hcnt_ff == 3'd3) begin
                        hcnt_ff <= '0;
                        // Only the low byte of the code point is kept.
                        if (32'(vlen_ff) + 1 < VALUE_BYTES) begin
                           val_ff[vlen_ff[VW-1:0]] <= cc;
                           vlen_ff <= VW'(vlen_ff) + 1'b1;
                        end
                        phase_ff <= PH_Q_VALUE;
                     end else begin
                        hcnt_ff <= hcnt_ff + 3'd1;
                     end
                  end
                  PH_PRE_DONE: begin
                     if (c == CH_COMMA) begin
                        if (lidx_ff[level_ff][8]) phase_ff <= PH_PRE_NAME;
                        else begin
                           cut_i_ff    <= plen_ff;
                           cut_mark_ff <= CH_LBRACK;
                           cut_kind_ff <= CT_NEXT_ITEM;
                           step_ff     <= ST_CUT;
                        end
                     end else if (c == CH_RBRACK) begin
                        if (level_ff == '0) phase_ff <= PH_ERROR;
                        else begin
                           cut_i_ff    <= plen_ff;
                           cut_mark_ff <= CH_SEP;
                           cut_kind_ff <= CT_CLOSE_ARR;
                           step_ff     <= ST_CUT;
                        end
                     end else if (c == CH_RBRACE) begin
                        if (level_ff == '0) phase_ff <= PH_ERROR;
                        else if (!prev_lidx[8]) begin
                           cut_i_ff    <= plen_ff;
                           cut_mark_ff <= CH_LBRACK;
                           cut_kind_ff <= CT_OBJ_CLOSE;
                           step_ff     <= ST_CUT;
                        end else if (level_ff > DW'(2)) begin
                           cut_i_ff    <= plen_ff;
                           cut_mark_ff <= CH_SEP;
                           cut_kind_ff <= CT_CLOSE_SEP;
                           step_ff     <= ST_CUT;
                        end else if (level_ff == DW'(2)) begin
                           plen_ff  <= '0;
                           level_ff <= DW'(1);
                        end else begin
                           phase_ff <= PH_DONE;
                           level_ff <= '0;
                        end
                     end
                  end
                  default: phase_ff <= PH_ERROR;
                  endcase
               end
            end
         end
         ST_APPEND: begin
            // One path byte a cycle; bytes past the limit are dropped.
            if (ap_i_ff < ap_n_ff) begin
               if (32'(plen_ff) + 1 < PATH_BYTES) begin
                  path_ff[plen_ff[PW-1:0]] <= ap_ff[ap_i_ff];
                  plen_ff <= PW'(plen_ff) + 1'b1;
               end
               ap_i_ff <= ap_i_ff + 3'd1;
            end else if (ap_key_ff && ap_k_ff < klen_ff) begin
               if (32'(plen_ff) + 1 < PATH_BYTES) begin
                  path_ff[plen_ff[PW-1:0]] <= key_ff[ap_k_ff[KW-1:0]];
                  plen_ff <= PW'(plen_ff) + 1'b1;
               end
               ap_k_ff <= KW'(ap_k_ff) + 1'b1;
            end else if (ap_emit_ff) begin
               ev_kind_ff    <= 1'b0;
               seg_ff        <= SG_PATH;
               ei_ff         <= '0;
               ecount_ff     <= '0;
               open_after_ff <= ap_open_ff;
               open_obj_ff   <= ap_obj_ff;
               ap_redo_ff    <= 1'b0;
               step_ff       <= ST_EMIT;
            end else begin
               if (ap_open_ff) begin
                  if (32'(level_ff) >= MAX_DEPTH) phase_ff <= PH_ERROR;
                  else begin
                     level_ff <= DW'(level_ff + 1'b1);
                     lidx_ff[DW'(level_ff + 1'b1)] <= {ap_obj_ff, 8'h00};
                     phase_ff <= ap_obj_ff ? PH_PRE_NAME : PH_PRE_ITEM;
                  end
               end
               redo_ff <= ap_redo_ff;
               step_ff <= ST_IDLE;
            end
         end
         ST_CUT: begin
            if (cut_i_ff == '0) begin
               phase_ff <= PH_ERROR;
               step_ff  <= ST_IDLE;
            end else if (path_ff[PW'(cut_i_ff - 1'b1)] == cut_mark_ff) begin
               plen_ff <= PW'(cut_i_ff - 1'b1);
               step_ff <= ST_IDLE;
               case (cut_kind_ff)
               CT_NEXT_ITEM: begin
                  lidx_ff[level_ff] <= {lidx_ff[level_ff][8], 8'(cur_idx + 8'd1)};
                  phase_ff <= PH_PRE_ITEM;
               end
               CT_CLOSE_ARR: level_ff <= DW'(level_ff - 1'b1);
               CT_POST_CLOSE: begin
                  level_ff <= DW'(level_ff - 1'b1);
                  phase_ff <= PH_PRE_DONE;
               end
               CT_OBJ_CLOSE: begin
                  level_ff <= DW'(level_ff - 1'b1);
                  phase_ff <= PH_POST_ITEM;
               end
               CT_CLOSE_SEP: level_ff <= DW'(level_ff - 1'b1);
               default: ;
               endcase
            end else begin
               cut_i_ff <= PW'(cut_i_ff - 1'b1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               eb = 8'h00;
               ev = 1'b1;
               lastseg = 1'b0;
               case (seg_ff)
               SG_PATH: begin
                  if (ei_ff < plen_ff) eb = path_ff[ei_ff[PW-1:0]];
                  else if (ev_kind_ff) begin
                     eb = CH_SEP;
                  end else begin
                     ev = 1'b0;
                     lastseg = 1'b1;
                  end
               end
               SG_KEY: eb = key_ff[ei_ff[KW-1:0]];
               SG_VALUE: begin
                  if (vlen_ff != '0) eb = val_ff[ei_ff[VW-1:0]];
                  else ev = 1'b0;
               end
               default: ;
               endcase
               // Decide where the run goes next.
               case (seg_ff)
               SG_PATH: begin
                  if (ei_ff < plen_ff) begin
                     if (ei_ff + 1'b1 < plen_ff) ei_ff <= ei_ff + 1'b1;
                     else if (ev_kind_ff) begin
                        seg_ff <= SG_SEP;
                     end else lastseg = 1'b1;
                  end else if (ev_kind_ff) begin
                     // Empty path: this word is the separator.
                     seg_ff <= (klen_ff != '0) ? SG_KEY : SG_VALUE;
                     ei_ff  <= '0;
                  end
               end
               SG_SEP: begin
                  eb = CH_SEP;
                  seg_ff <= (klen_ff != '0) ? SG_KEY : SG_VALUE;
                  ei_ff  <= '0;
               end
               SG_KEY: begin
                  if (32'(ei_ff) + 1 < 32'(klen_ff)) ei_ff <= ei_ff + 1'b1;
                  else begin
                     seg_ff <= SG_VALUE;
                     ei_ff  <= '0;
                  end
               end
               SG_VALUE: begin
                  if (vlen_ff == '0 || 32'(ei_ff) + 1 >= 32'(vlen_ff)) lastseg = 1'b1;
                  else ei_ff <= ei_ff + 1'b1;
               end
               default: lastseg = 1'b1;
               endcase
               elast = lastseg || (ecount_ff == 7'(MAX_RESULTS - 1));
               if (ecount_ff < 7'(MAX_RESULTS)) begin
                  out_ff.event_kind <= ev_kind_ff;
                  out_ff.depth_now  <= 4'(level_ff);
                  out_ff.part       <= (seg_ff == SG_VALUE);
                  out_ff.text_out   <= ev ? eb : 8'h00;
                  out_ff.text_valid <= ev;
                  out_ff.last       <= elast;
                  ov = 1'b1;
               end
               ecount_ff <= ecount_ff + 7'd1;
               if (lastseg) begin
                  step_ff <= ST_EMIT_WAIT;
               end
            end
         end
         ST_EMIT_WAIT: begin
            if (open_after_ff) begin
               if (32'(level_ff) >= MAX_DEPTH) phase_ff <= PH_ERROR;
               else begin
                  level_ff <= DW'(level_ff + 1'b1);
                  lidx_ff[DW'(level_ff + 1'b1)] <= {open_obj_ff, 8'h00};
                  phase_ff <= open_obj_ff ? PH_PRE_NAME : PH_PRE_ITEM;
               end
            end
            redo_ff <= ap_redo_ff;
            step_ff <= ST_IDLE;
         end
         default: step_ff <= ST_IDLE;
         endcase
         out_v_ff <= ov;
      end
   end

endmodule

// ===== src/json_stream_path_value_parser.sv =====
// Top level of the streaming JSON path/value parser.
// Instantiates jspv_front (input queue) and jspv_back (parser); uses jspv_pkg.
//
//   channel | ports                        | direction
//   req     | req_valid, req_stall, req_word | in
//   rsp     | rsp_valid, rsp_stall, rsp_word | out
//
// A byte that needs only a state step is handled in the idle step alone.
// A path append writes its generated bytes and then any key bytes one at a
// time before a closing step, a cut search scans path bytes backward, and an
// event plays out its words in order before a closing step; rsp stalls hold it.
// Reset is synchronous; restart words clear parser state.
// The two-word input queue takes words while the parser is busy, then stalls.
module json_stream_path_value_parser #(
   parameter int PATH_BYTES  = 32,
   parameter int KEY_BYTES   = 16,
   parameter int VALUE_BYTES = 16,
   parameter int MAX_DEPTH   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  jspv_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output jspv_pkg::rsp_word_type rsp_word
);
   import jspv_pkg::*;

   logic         q_valid, q_take;
   req_word_type q_word;

   jspv_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .q_valid, .q_take, .q_word
   );

   jspv_back #(
      .PATH_BYTES(PATH_BYTES), .KEY_BYTES(KEY_BYTES),
      .VALUE_BYTES(VALUE_BYTES), .MAX_DEPTH(MAX_DEPTH)
   ) u_back (
      .clock, .reset, .q_valid, .q_take, .q_word,
      .rsp_valid, .rsp_stall, .rsp_word
   );

endmodule

// ===== tb/testbench.sv =====
// Testbench for the streaming JSON path/value parser.
// Feeds JSON text words, predicts the path/value event stream and checks it word by word.
// Depends on jspv_pkg and json_stream_path_value_parser.
module testbench;
   import jspv_pkg::*;

   localparam int PATH_LEN  = 32;
   localparam int KEY_LEN   = 16;
   localparam int VAL_LEN   = 16;
   localparam int DEPTH_MAX = 8;
   localparam int WATCHDOG  = 20000;

   typedef enum int {
      PS_INIT, PS_PRE_NAME, PS_Q_NAME, PS_ASSIGN, PS_PRE_VALUE, PS_Q_VALUE,
      PS_ESC, PS_ESCU, PS_NUM, PS_PRE_ITEM, PS_POST_ITEM, PS_PRE_DONE,
      PS_DONE, PS_ERROR
   } phase_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  quiet_cycles = 0;
   bit  failed = 1'b0;

   rsp_word_type expected_words[$];

   // Predictor state.
   phase_type  pr_phase;
   int         pr_level;
   logic [8:0] pr_index[DEPTH_MAX+1];
   logic [7:0] pr_path[PATH_LEN];
   int         pr_plen;
   logic [7:0] pr_key[KEY_LEN];
   int         pr_klen;
   logic [7:0] pr_val[VAL_LEN];
   int         pr_vlen;
   logic [15:0] pr_hex;
   int         pr_hcnt;
   bit         pr_hstop;
   int         pr_emitted;

   json_stream_path_value_parser i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always #4 clock = ~clock;

   task automatic clear_parser();
      pr_phase = PS_INIT;
      pr_level = 0;
      foreach (pr_index[i]) pr_index[i] = '0;
      pr_index[0] = 9'h100;
      foreach (pr_path[i]) pr_path[i] = '0;
      foreach (pr_key[i]) pr_key[i] = '0;
      foreach (pr_val[i]) pr_val[i] = '0;
      pr_plen = 0;
      pr_klen = 0;
      pr_vlen = 0;
      pr_hex = '0;
      pr_hcnt = 0;
      pr_hstop = 1'b0;
   endtask

   function automatic bit blank_char(logic [7:0] c);
      return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic bit digit_char(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   task automatic queue_word(bit kind, bit prt, logic [7:0] c, bit vld);
      rsp_word_type w;
      if (pr_emitted >= MAX_RESULTS) return;
      w.event_kind = kind;
      w.depth_now = 4'(pr_level);
      w.part = prt;
      w.text_out = vld ? c : 8'h00;
      w.text_valid = vld;
      w.last = 1'b0;
      expected_words.push_back(w);
      pr_emitted++;
   endtask

   task automatic close_event();
      if (pr_emitted > 0) expected_words[$].last = 1'b1;
   endtask

   task automatic path_put(logic [7:0] c);
      if (pr_plen + 1 < PATH_LEN) begin
         pr_path[pr_plen] = c;
         pr_plen++;
      end
   endtask

   task automatic emit_container_path();
      for (int i = 0; i < pr_plen; i++) queue_word(1'b0, 1'b0, pr_path[i], 1'b1);
      if (pr_plen == 0) queue_word(1'b0, 1'b0, 8'h00, 1'b0);
      close_event();
   endtask

   task automatic emit_completed_value();
      for (int i = 0; i < pr_plen; i++) queue_word(1'b1, 1'b0, pr_path[i], 1'b1);
      queue_word(1'b1, 1'b0, CH_SEP, 1'b1);
      for (int i = 0; i < pr_klen; i++) queue_word(1'b1, 1'b0, pr_key[i], 1'b1);
      for (int i = 0; i < pr_vlen; i++) queue_word(1'b1, 1'b1, pr_val[i], 1'b1);
      if (pr_vlen == 0) queue_word(1'b1, 1'b1, 8'h00, 1'b0);
      close_event();
   endtask

   task automatic value_put(logic [7:0] c);
      if (pr_vlen + 1 < VAL_LEN) begin
         pr_val[pr_vlen] = c;
         pr_vlen++;
      end
   endtask

   function automatic bit open_nest(bit obj);
      if (pr_level >= DEPTH_MAX) begin
         pr_phase = PS_ERROR;
         return 1'b0;
      end
      pr_level++;
      pr_index[pr_level] = obj ? 9'h100 : 9'h000;
      return 1'b1;
   endfunction

   function automatic bit cut_path(logic [7:0] mark);
      for (int i = pr_plen - 1; i >= 0; i--) begin
         if (pr_path[i] == mark) begin
            pr_plen = i;
            return 1'b1;
         end
      end
      pr_phase = PS_ERROR;
      return 1'b0;
   endfunction

   task automatic bump_index();
      pr_index[pr_level][7:0] = pr_index[pr_level][7:0] + 8'd1;
   endtask

   // One pass over a byte; returns 1 when the byte is consumed.
   task automatic parse_char(logic [7:0] c, output bit done);
      bit blanks;
      int n;
      logic [4:0] h;
      int nl;
      done = 1'b1;
      blanks = !(pr_phase inside {PS_Q_NAME, PS_Q_VALUE, PS_ESC, PS_ESCU, PS_NUM});
      if (blanks && blank_char(c)) return;
      case (pr_phase)
         PS_ERROR: ;
         PS_DONE: pr_phase = PS_ERROR;
         PS_INIT: begin
            if (c != CH_LBRACE) pr_phase = PS_ERROR;
            else if (open_nest(1'b1)) pr_phase = PS_PRE_NAME;
         end
         PS_PRE_NAME: begin
            if (c == CH_QUOTE) begin
               pr_klen = 0;
               pr_vlen = 0;
               pr_phase = PS_Q_NAME;
            end else begin
               pr_phase = PS_PRE_DONE;
               done = 1'b0;
            end
         end
         PS_Q_NAME: begin
            if (c != CH_QUOTE) begin
               if (pr_klen + 1 < KEY_LEN) begin
                  pr_key[pr_klen] = c;
                  pr_klen++;
               end
            end else pr_phase = PS_ASSIGN;
         end
         PS_ASSIGN: pr_phase = (c == CH_COLON) ? PS_PRE_VALUE : PS_ERROR;
         PS_PRE_ITEM: begin
            n = pr_index[pr_level][7:0];
            path_put(CH_LBRACK);
            if (n >= 100) path_put(8'(48 + n / 100));
            if (n >= 10) path_put(8'(48 + (n / 10) % 10));
            path_put(8'(48 + n % 10));
            path_put(CH_RBRACK);
            if (c == CH_LBRACE) begin
               if (open_nest(1'b1)) pr_phase = PS_PRE_NAME;
            end else begin
               pr_klen = 0;
               pr_phase = PS_PRE_VALUE;
               done = 1'b0;
            end
         end
         PS_POST_ITEM: begin
            if (c == CH_COMMA) begin
               bump_index();
               pr_phase = PS_PRE_ITEM;
            end else if (c == CH_RBRACK) begin
               if (pr_level == 0) pr_phase = PS_ERROR;
               else if (pr_level > 2) begin
                  if (cut_path(CH_SEP)) begin
                     pr_level--;
                     pr_phase = PS_PRE_DONE;
                  end
               end else begin
                  pr_plen = 0;
                  pr_level--;
                  pr_phase = PS_PRE_DONE;
               end
            end
         end
         PS_PRE_VALUE: begin
            pr_vlen = 0;
            if (c == CH_QUOTE) pr_phase = PS_Q_VALUE;
            else if (c == CH_LBRACE || c == CH_LBRACK) begin
               if (pr_plen != 0) path_put(CH_SEP);
               for (int i = 0; i < pr_klen; i++) path_put(pr_key[i]);
               emit_container_path();
               if (open_nest(c == CH_LBRACE))
                  pr_phase = (c == CH_LBRACE) ? PS_PRE_NAME : PS_PRE_ITEM;
            end else if (digit_char(c)) begin
               pr_phase = PS_NUM;
               done = 1'b0;
            end
         end
         PS_NUM: begin
            if (digit_char(c) || c == CH_DOT) value_put(c);
            else begin
               emit_completed_value();
               pr_phase = PS_PRE_DONE;
               done = 1'b0;
            end
         end
         PS_Q_VALUE: begin
            if (c == CH_BSLASH) pr_phase = PS_ESC;
            else if (c != CH_QUOTE) value_put(c);
            else begin
               emit_completed_value();
               pr_phase = PS_PRE_DONE;
            end
         end
         PS_ESC: begin
            if (c == "u") begin
               pr_hex = '0;
               pr_hcnt = 0;
               pr_hstop = 1'b0;
               pr_phase = PS_ESCU;
            end else begin
               case (c)
                  "b": c = 8'd8;
                  "f": c = 8'd12;
                  "n": c = 8'd10;
                  "r": c = 8'd13;
                  "t": c = 8'd9;
                  default: ;
               endcase
               value_put(c);
               pr_phase = PS_Q_VALUE;
            end
         end
         PS_ESCU: begin
            if (c >= "0" && c <= "9") h = 5'(c - "0");
            else if (c >= "a" && c <= "f") h = 5'(c - "a" + 10);
            else if (c >= "A" && c <= "F") h = 5'(c - "A" + 10);
            else h = 5'd16;
            if (h >= 16) pr_hstop = 1'b1;
            else if (!pr_hstop) pr_hex = {pr_hex[11:0], h[3:0]};
            pr_hcnt++;
            if (pr_hcnt >= 4) begin
               value_put(pr_hex[7:0]);
               pr_hcnt = 0;
               pr_phase = PS_Q_VALUE;
            end
         end
         PS_PRE_DONE: begin
            if (c == CH_COMMA) begin
               if (pr_index[pr_level][8]) pr_phase = PS_PRE_NAME;
               else if (cut_path(CH_LBRACK)) begin
                  bump_index();
                  pr_phase = PS_PRE_ITEM;
               end
            end else if (c == CH_RBRACK) begin
               if (pr_level == 0) pr_phase = PS_ERROR;
               else if (cut_path(CH_SEP)) pr_level--;
            end else if (c == CH_RBRACE) begin
               if (pr_level == 0) pr_phase = PS_ERROR;
               else begin
                  nl = pr_level - 1;
                  if (!pr_index[nl][8]) begin
                     if (cut_path(CH_LBRACK)) begin
                        pr_phase = PS_POST_ITEM;
                        pr_level = nl;
                     end
                  end else if (nl > 1) begin
                     if (cut_path(CH_SEP)) pr_level = nl;
                  end else begin
                     if (nl == 1) pr_plen = 0;
                     else pr_phase = PS_DONE;
                     pr_level = nl;
                  end
               end
            end
         end
         default: pr_phase = PS_ERROR;
      endcase
   endtask

   task automatic predict_word(req_word_type w);
      bit done;
      pr_emitted = 0;
      if (w.op == OP_RESTART) begin
         clear_parser();
         return;
      end
      for (int g = 0; g < 8; g++) begin
         parse_char(w.text_in, done);
         if (done) break;
      end
   endtask

   // Sends one word; the prediction is made when the word is accepted.
   // Valid stays high between words sent back to back.
   task automatic send_word(logic op, logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_word.op <= op;
      req_word.text_in <= c;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word('{op: op, text_in: c});
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_word(OP_PARSE, s[i]);
   endtask

   task automatic restart();
      send_word(OP_RESTART, 8'h00);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word %h", rsp_word);
            failed = 1'b1;
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_word.event_kind !== exp_w.event_kind) begin
               $error("event_kind exp %0d got %0d", exp_w.event_kind, rsp_word.event_kind);
               failed = 1'b1;
            end
            if (rsp_word.depth_now !== exp_w.depth_now) begin
               $error("depth_now exp %0d got %0d", exp_w.depth_now, rsp_word.depth_now);
               failed = 1'b1;
            end
            if (rsp_word.part !== exp_w.part) begin
               $error("part exp %0d got %0d", exp_w.part, rsp_word.part);
               failed = 1'b1;
            end
            if (rsp_word.text_out !== exp_w.text_out) begin
               $error("text_out exp %h got %h", exp_w.text_out, rsp_word.text_out);
               failed = 1'b1;
            end
            if (rsp_word.text_valid !== exp_w.text_valid) begin
               $error("text_valid exp %0d got %0d", exp_w.text_valid, rsp_word.text_valid);
               failed = 1'b1;
            end
            if (rsp_word.last !== exp_w.last) begin
               $error("last exp %0d got %0d", exp_w.last, rsp_word.last);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic test_directed();
      // Escapes, unicode with a stopped hex run, a number, nested containers,
      // an empty value, blanks, a zero byte and high bytes.
      send_text("{ \"k\":\"a\\n\\u00e9\\uZ41x\", \"n\":12.5,");
      send_text("\"o\":{\"a\":[1,\"\",{\"b\":7}]}}");
      send_word(OP_PARSE, 8'h00);
      restart();
      send_word(OP_PARSE, 8'hFF);
      restart();
      send_text("{\"\":\"\"}");
      drain();
   endtask

   task automatic test_limits();
      // Over-deep nesting, long key/value truncation, path truncation at the limit.
      restart();
      send_text("{\"a\":{\"b\":{\"c\":{\"d\":{\"e\":{\"f\":{\"g\":{\"h\":{}}}}}}}}}");
      restart();
      send_text("{\"abcdefghijklmnopqrstu\":{\"vwxyzabcdefghijklmn\":{");
      send_text("\"opqrstuvwxyz0123\":\"0123456789abcdefghijk\\t\\b\\f\\r\\q\"}}}");
      restart();
      send_text("{\"a\":[0,1,2,3,4,5,6,7,8,9,10,11]}");
      restart();
      send_text("{]");
      drain();
   endtask

   function automatic string random_key();
      string s = "";
      int n = $urandom_range(0, 18);
      for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(97, 122)))};
      return s;
   endfunction

   function automatic string random_scalar();
      string s = "";
      int n;
      case ($urandom_range(5))
         0, 1: begin
            n = $urandom_range(1, 18);
            for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(48, 57)))};
            if ($urandom_range(1)) s = {s, ".5"};
         end
         2: s = "true";
         default: begin
            s = "\"";
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
               case ($urandom_range(7))
                  0: s = {s, "\\n"};
                  1: s = {s, "\\u00", string'(8'($urandom_range(65, 70))), "9"};
                  default: s = {s, string'(8'($urandom_range(35, 126) == 92 ? 65 : 0) +
                               8'($urandom_range(35, 91)))};
               endcase
            s = {s, "\""};
         end
      endcase
      return s;
   endfunction

   function automatic string random_value(int lvl);
      string s;
      int n;
      if (lvl >= 3 || $urandom_range(2) != 0) return random_scalar();
      n = $urandom_range(0, 3);
      if ($urandom_range(1)) begin
         s = "{";
         for (int i = 0; i < n; i++) begin
            if (i != 0) s = {s, ","};
            s = {s, "\"", random_key(), "\": ", random_value(lvl + 1)};
         end
         return {s, "}"};
      end
      s = "[";
      for (int i = 0; i < n; i++) begin
         if (i != 0) s = {s, ", "};
         s = {s, random_value(lvl + 1)};
      end
      return {s, "]"};
   endfunction

   task automatic test_random(int budget);
      int sent = 0;
      string doc;
      while (sent < budget) begin
         restart();
         if ($urandom_range(9) == 0) begin
            // Noise: arbitrary bytes, every bit pattern possible.
            for (int i = 0; i < 12; i++) send_word(OP_PARSE, 8'($urandom_range(255)));
            sent += 12;
         end else begin
            doc = {"{\"", random_key(), "\":", random_value(1), "}"};
            if ($urandom_range(7) == 0) doc = doc.substr(0, doc.len() / 2);
            send_text(doc);
            sent += doc.len();
         end
      end
   endtask

   initial begin
      clear_parser();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_limits();
      test_random(40);
      drain();
      send_idle_pct = 70;
      test_random(40);
      send_idle_pct = 0;
      stall_pct = 70;
      test_random(40);
      drain();
      send_idle_pct = 19;
      stall_pct = 19;
      test_random(40);
      drain();
      stall_pct = 0;
      repeat (100) @(negedge clock);
      if (!failed && expected_words.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

// ===== json_stream_path_value_parser.f =====
src/jspv_pkg.sv
src/jspv_front.sv
src/jspv_back.sv
src/json_stream_path_value_parser.sv
tb/testbench.sv
